### hw/rtl/ibd_pkg.sv
`timescale 1ns / 1ps

package ibd_pkg;

    localparam int unsigned STORE_DEPTH = 6;
    localparam int unsigned NUM_CLASSES = 9;
    localparam int unsigned LEN_W       = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    typedef enum logic [3:0] {
        CLS_ALU_RM      = 4'd0,
        CLS_ALU_IMM_RM  = 4'd1,
        CLS_ALU_IMM_ACC = 4'd2,
        CLS_MOV_RM_REG  = 4'd3,
        CLS_MOV_MEM_ACC = 4'd4,
        CLS_MOV_IMM_REG = 4'd5,
        CLS_MOV_IMM_RM  = 4'd6,
        CLS_JCC         = 4'd7,
        CLS_LOOP        = 4'd8,
        CLS_UNKNOWN     = 4'd9
    } op_class_t;

    // Entry i belongs to class i; lowest index wins.
    localparam logic [NUM_CLASSES-1:0][7:0] CLASS_MASK = {
        8'b11111100, 8'b11110000, 8'b11111110, 8'b11110000, 8'b11111100,
        8'b11111100, 8'b11000110, 8'b11111100, 8'b11000100
    };
    localparam logic [NUM_CLASSES-1:0][7:0] CLASS_CODE = {
        8'b11100000, 8'b01110000, 8'b11000110, 8'b10110000, 8'b10100000,
        8'b10001000, 8'b00000100, 8'b10000000, 8'b00000000
    };

    typedef struct packed {
        logic [STORE_DEPTH-1:0][7:0] bytes;
        logic [LEN_W-1:0]            len;
    } instr_rec_t;

    typedef struct packed {
        logic       valid;
        instr_rec_t rec;
    } instr_msg_t;

    typedef struct packed {
        logic [1:0]        pad;
        logic [LEN_W-1:0]  length;
        logic signed [7:0] jump_offset;
        logic [15:0]       immediate;
        logic signed [15:0] displacement;
        logic              sign_extend;
        logic              to_register;
        logic              wide;
        logic [2:0]        rm_field;
        logic [2:0]        reg_field;
        logic [1:0]        mode_field;
        logic [3:0]        sub_op;
        op_class_t         op_class;
    } result_t;

    localparam int unsigned OUT_W = $bits(result_t);

    function automatic op_class_t classify(input logic [7:0] b);
        op_class_t c;
        c = CLS_UNKNOWN;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if ((b & CLASS_MASK[i]) == CLASS_CODE[i])
            begin
                c = op_class_t'(4'(i));
            end
        end
        return c;
    endfunction

    function automatic logic has_modrm(input op_class_t c);
        return c inside {CLS_ALU_RM, CLS_ALU_IMM_RM, CLS_MOV_RM_REG, CLS_MOV_IMM_RM};
    endfunction

    function automatic logic wide_of(input op_class_t c, input logic [7:0] b);
        logic w;
        w = 1'b0;
        if (c == CLS_MOV_IMM_REG)
        begin
            w = b[3];
        end
        else if (c <= CLS_MOV_IMM_RM)
        begin
            w = b[0];
        end
        return w;
    endfunction

    function automatic logic [1:0] imm_len(input op_class_t c, input logic [7:0] b);
        logic [1:0] n;
        logic       w;
        w = wide_of(c, b);
        case (c)
            CLS_ALU_IMM_RM:  n = (w && !b[1]) ? 2'd2 : 2'd1;
            CLS_ALU_IMM_ACC,
            CLS_MOV_IMM_REG,
            CLS_MOV_IMM_RM:  n = w ? 2'd2 : 2'd1;
            CLS_MOV_MEM_ACC: n = 2'd2;
            default:         n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] m);
        logic [1:0] n;
        case (m[7:6])
            2'b01:   n = 2'd1;
            2'b10:   n = 2'd2;
            2'b00:   n = (m[2:0] == 3'b110) ? 2'd2 : 2'd0;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

### hw/rtl/ibd_front.sv
`timescale 1ns / 1ps

module ibd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           code_byte,
    input  logic                 queue_full,
    output ibd_pkg::instr_msg_t  push
);

    logic [ibd_pkg::LEN_W-1:0]              taken_reg;
    logic [ibd_pkg::LEN_W-1:0]              taken_next;
    logic [ibd_pkg::STORE_DEPTH-1:0][7:0]   bytes_reg;
    logic [ibd_pkg::STORE_DEPTH-1:0][7:0]   bytes_next;
    logic [ibd_pkg::LEN_W-1:0]              count;
    logic [ibd_pkg::LEN_W-1:0]              needed;
    ibd_pkg::op_class_t                     cls;
    logic                                   accept;
    logic                                   complete;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < ibd_pkg::STORE_DEPTH; i++)
        begin
            bytes_next[i] = (taken_reg == ibd_pkg::LEN_W'(i)) ? code_byte : bytes_reg[i];
        end
    end

    assign count = taken_reg + ibd_pkg::LEN_W'(1);
    assign cls   = ibd_pkg::classify(bytes_next[0]);

    // Length known so far, from the opcode and (once here) the ModRM word.
    always_comb
    begin
        case (cls)
            ibd_pkg::CLS_UNKNOWN: needed = ibd_pkg::LEN_W'(1);
            ibd_pkg::CLS_JCC,
            ibd_pkg::CLS_LOOP:    needed = ibd_pkg::LEN_W'(2);
            default:
            begin
                if (ibd_pkg::has_modrm(cls))
                begin
                    if (count < ibd_pkg::LEN_W'(2))
                    begin
                        needed = ibd_pkg::LEN_W'(2);
                    end
                    else
                    begin
                        needed = ibd_pkg::LEN_W'(2)
                               + ibd_pkg::LEN_W'(ibd_pkg::disp_len(bytes_next[1]))
                               + ibd_pkg::LEN_W'(ibd_pkg::imm_len(cls, bytes_next[0]));
                    end
                end
                else
                begin
                    needed = ibd_pkg::LEN_W'(1)
                           + ibd_pkg::LEN_W'(ibd_pkg::imm_len(cls, bytes_next[0]));
                end
            end
        endcase
    end

    assign complete   = count >= needed;
    assign taken_next = complete ? '0 : count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else if (accept)
        begin
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= bytes_next;
        end
    end

    assign push.valid     = accept && complete;
    assign push.rec.bytes = bytes_next;
    assign push.rec.len   = count;

endmodule

### hw/rtl/ibd_queue.sv
`timescale 1ns / 1ps

module ibd_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ibd_pkg::instr_msg_t  push,
    output logic                 full,
    input  logic                 pop_ready,
    output ibd_pkg::instr_msg_t  head
);

    ibd_pkg::instr_rec_t              mem [ibd_pkg::QUEUE_DEPTH];
    logic [ibd_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ibd_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [ibd_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ibd_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [ibd_pkg::QCNT_W-1:0]       count_reg;
    logic [ibd_pkg::QCNT_W-1:0]       count_next;
    logic                             push_en;
    logic                             pop_en;

    assign full       = count_reg == ibd_pkg::QCNT_W'(ibd_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.rec   = mem[rd_ptr_reg];

    assign push_en = push.valid && !full;
    assign pop_en  = head.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == ibd_pkg::QPTR_W'(ibd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + ibd_pkg::QPTR_W'(1);
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == ibd_pkg::QPTR_W'(ibd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + ibd_pkg::QPTR_W'(1);
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + ibd_pkg::QCNT_W'(1);
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - ibd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

endmodule

### hw/rtl/ibd_back.sv
`timescale 1ns / 1ps

module ibd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ibd_pkg::instr_msg_t  head,
    output logic                 pop_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ibd_pkg::result_t     out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    ibd_pkg::result_t   out_data_reg;
    ibd_pkg::result_t   out_data_next;
    logic               load;

    function automatic ibd_pkg::result_t decode(input ibd_pkg::instr_rec_t rec);
        ibd_pkg::result_t   r;
        ibd_pkg::op_class_t c;
        logic [7:0]         b;
        logic [7:0]         m;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic               w;
        logic [1:0]         il;
        logic [1:0]         dl;
        logic [2:0]         p;
        b  = rec.bytes[0];
        m  = rec.bytes[1];
        c  = ibd_pkg::classify(b);
        w  = ibd_pkg::wide_of(c, b);
        il = ibd_pkg::imm_len(c, b);
        dl = ibd_pkg::disp_len(m);
        r  = '0;
        r.op_class   = c;
        r.mode_field = 2'b11;
        r.wide       = w;
        r.length     = rec.len;
        p            = 3'd1;
        if (c == ibd_pkg::CLS_ALU_IMM_RM)
        begin
            r.sign_extend = b[1];
        end
        if (ibd_pkg::has_modrm(c))
        begin
            r.mode_field = m[7:6];
            r.reg_field  = m[5:3];
            r.rm_field   = m[2:0];
            p            = 3'd2 + 3'(dl);
            if (dl == 2'd1)
            begin
                r.displacement = {{8{rec.bytes[2][7]}}, rec.bytes[2]};
            end
            else if (dl == 2'd2)
            begin
                r.displacement = {rec.bytes[3], rec.bytes[2]};
            end
        end
        // Immediate or direct address follows the opcode, or the ModRM and displacement words.
        lo = rec.bytes[p];
        hi = rec.bytes[p + 3'd1];
        if (il == 2'd2)
        begin
            r.immediate = {hi, lo};
        end
        else if (il == 2'd1)
        begin
            if (c == ibd_pkg::CLS_ALU_IMM_RM && b[1] && w && lo[7])
            begin
                r.immediate = {8'hFF, lo};
            end
            else
            begin
                r.immediate = {8'h00, lo};
            end
        end
        case (c)
            ibd_pkg::CLS_ALU_RM:
            begin
                r.sub_op      = {1'b0, b[5:3]};
                r.to_register = b[1];
            end
            ibd_pkg::CLS_ALU_IMM_RM:
            begin
                r.sub_op = {1'b0, m[5:3]};
            end
            ibd_pkg::CLS_ALU_IMM_ACC:
            begin
                r.sub_op      = {1'b0, b[5:3]};
                r.to_register = 1'b1;
            end
            ibd_pkg::CLS_MOV_RM_REG:
            begin
                r.to_register = b[1];
            end
            ibd_pkg::CLS_MOV_MEM_ACC:
            begin
                r.to_register = ~b[1];
            end
            ibd_pkg::CLS_MOV_IMM_REG:
            begin
                r.reg_field   = b[2:0];
                r.to_register = 1'b1;
            end
            ibd_pkg::CLS_JCC:
            begin
                r.sub_op      = b[3:0];
                r.jump_offset = m;
            end
            ibd_pkg::CLS_LOOP:
            begin
                r.sub_op      = {2'b00, b[1:0]};
                r.jump_offset = m;
            end
            default:
            begin
                r.sub_op = '0;
            end
        endcase
        return r;
    endfunction

    assign pop_ready = !out_valid_reg || out_ready;
    assign load      = head.valid && pop_ready;

    assign out_valid_next = load || (out_valid_reg && !out_ready);
    assign out_data_next  = decode(head.rec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/x86_16_instruction_byte_decoder_unit.sv
`timescale 1ns / 1ps
// 8086 instruction byte decoder (opcode subset).
// Input stream: one code byte per word on s_tdata. Output stream: one word per
// finished instruction on m_tdata with the decoded fields and the length.
// Bytes that start no known opcode come out at once as one-byte unknown
// instructions.
// Throughput: one byte per cycle, sustained while the queue is not full,
// independent of instruction length. The queue entry is written at the edge
// that takes the last byte of an instruction; the output register loads from
// the queue, raising m_tvalid, once it is free to take a new word.
// The front end gathers bytes and finds instruction boundaries; the back end
// decodes a whole instruction from the queue into the output register.
// Stall: while m_tready is low the output word holds; the queue fills and
// s_tready drops once both queue entries are taken.
// Reset: rst_n clears the byte count, the queue and the output valid; the next
// byte accepted is taken as the first byte of an instruction.
module x86_16_instruction_byte_decoder_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] code_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [3:0] op_class, [7:4] sub_op, [9:8] mode_field, [12:10] reg_field,
    // [15:13] rm_field, [16] wide, [17] to_register, [18] sign_extend,
    // [34:19] displacement, [50:35] immediate, [58:51] jump_offset,
    // [61:59] length, [63:62] zero
    output logic [ibd_pkg::OUT_W-1:0]   m_tdata
);

    ibd_pkg::instr_msg_t  push;
    ibd_pkg::instr_msg_t  head;
    ibd_pkg::result_t     res;
    logic                 queue_full;
    logic                 pop_ready;

    ibd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .code_byte  (s_tdata),
        .queue_full (queue_full),
        .push       (push)
    );

    ibd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (queue_full),
        .pop_ready  (pop_ready),
        .head       (head)
    );

    ibd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop_ready  (pop_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res)
    );

    assign m_tdata = res;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !queue_full)
        else $error("instruction pushed into a full queue");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.length != 3'd0 && res.length <= 3'd6))
        else $error("instruction length out of range");

    a_unknown_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.op_class == ibd_pkg::CLS_UNKNOWN) |-> res.length == 3'd1)
        else $error("unknown opcode not emitted as one byte");

endmodule

### verif/x86_16_instruction_byte_decoder_unit_tb.sv
`timescale 1ns / 1ps

module x86_16_instruction_byte_decoder_unit_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int IDLE_PCT    = 27;

    // Opcode classes in priority order, index = class number.
    localparam logic [7:0] OPC_MASK [9] = '{8'hC4, 8'hFC, 8'hC6, 8'hFC, 8'hFC,
                                             8'hF0, 8'hFE, 8'hF0, 8'hFC};
    localparam logic [7:0] OPC_CODE [9] = '{8'h00, 8'h80, 8'h04, 8'h88, 8'hA0,
                                             8'hB0, 8'hC6, 8'h70, 8'hE0};

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // [7:0] code_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [3:0] op_class, [7:4] sub_op, [9:8] mode_field, [12:10] reg_field,
    // [15:13] rm_field, [16] wide, [17] to_register, [18] sign_extend,
    // [34:19] displacement, [50:35] immediate, [58:51] jump_offset,
    // [61:59] length, [63:62] zero
    logic [ibd_pkg::OUT_W-1:0]  m_tdata;

    // Bytes of the instruction being gathered
    logic [7:0] instr_bytes [6];
    int         instr_count = 0;

    ibd_pkg::result_t decodes_due [$];
    int         error_count  = 0;
    int         stall_cycles = 0;
    bit         idle_en      = 1'b1;

    x86_16_instruction_byte_decoder_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ibd_pkg::op_class_t find_class(input logic [7:0] b);
        ibd_pkg::op_class_t c;
        c = ibd_pkg::CLS_UNKNOWN;
        for (int i = 0; i < 9; i++)
        begin
            if (c == ibd_pkg::CLS_UNKNOWN && (b & OPC_MASK[i]) == OPC_CODE[i])
            begin
                c = ibd_pkg::op_class_t'(4'(i));
            end
        end
        return c;
    endfunction

    function automatic bit takes_modrm(input ibd_pkg::op_class_t c);
        return c inside {ibd_pkg::CLS_ALU_RM, ibd_pkg::CLS_ALU_IMM_RM,
                         ibd_pkg::CLS_MOV_RM_REG, ibd_pkg::CLS_MOV_IMM_RM};
    endfunction

    function automatic logic wide_bit(input ibd_pkg::op_class_t c, input logic [7:0] op);
        if (c == ibd_pkg::CLS_MOV_IMM_REG)
        begin
            return op[3];
        end
        if (c <= ibd_pkg::CLS_MOV_IMM_RM)
        begin
            return op[0];
        end
        return 1'b0;
    endfunction

    function automatic int imm_bytes(input ibd_pkg::op_class_t c, input logic [7:0] op);
        logic w;
        w = wide_bit(c, op);
        case (c)
            ibd_pkg::CLS_ALU_IMM_RM:  return (w && !op[1]) ? 2 : 1;
            ibd_pkg::CLS_ALU_IMM_ACC,
            ibd_pkg::CLS_MOV_IMM_REG,
            ibd_pkg::CLS_MOV_IMM_RM:  return w ? 2 : 1;
            ibd_pkg::CLS_MOV_MEM_ACC: return 2;
            default:                  return 0;
        endcase
    endfunction

    function automatic int disp_bytes(input logic [7:0] m);
        case (m[7:6])
            2'b01:   return 1;
            2'b10:   return 2;
            2'b00:   return (m[2:0] == 3'b110) ? 2 : 0;
            default: return 0;
        endcase
    endfunction

    // Length of the current instruction as far as the gathered bytes tell it
    function automatic int bytes_required();
        ibd_pkg::op_class_t c;
        c = find_class(instr_bytes[0]);
        if (c == ibd_pkg::CLS_UNKNOWN)
        begin
            return 1;
        end
        if (c == ibd_pkg::CLS_JCC || c == ibd_pkg::CLS_LOOP)
        begin
            return 2;
        end
        if (takes_modrm(c))
        begin
            if (instr_count < 2)
            begin
                return 2;
            end
            return 2 + disp_bytes(instr_bytes[1]) + imm_bytes(c, instr_bytes[0]);
        end
        return 1 + imm_bytes(c, instr_bytes[0]);
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        logic [7:0]         op;
        logic [7:0]         m;
        ibd_pkg::op_class_t c;
        ibd_pkg::result_t   r;
        int                 p;
        int                 dl;
        int                 il;
        instr_bytes[instr_count] = b;
        instr_count++;
        if (instr_count >= bytes_required())
        begin
            op = instr_bytes[0];
            c  = find_class(op);
            r  = '0;
            r.op_class   = c;
            r.mode_field = 2'd3;
            r.length     = instr_count[2:0];
            r.wide       = wide_bit(c, op);
            il = imm_bytes(c, op);
            p  = 1;
            if (c == ibd_pkg::CLS_ALU_IMM_RM)
            begin
                r.sign_extend = op[1];
            end
            if (takes_modrm(c))
            begin
                m = instr_bytes[1];
                r.mode_field = m[7:6];
                r.reg_field  = m[5:3];
                r.rm_field   = m[2:0];
                dl = disp_bytes(m);
                if (dl == 1)
                begin
                    r.displacement = {{8{instr_bytes[2][7]}}, instr_bytes[2]};
                end
                else if (dl == 2)
                begin
                    r.displacement = {instr_bytes[3], instr_bytes[2]};
                end
                p = 2 + dl;
            end
            if (il == 2)
            begin
                r.immediate = {instr_bytes[p + 1], instr_bytes[p]};
            end
            else if (il == 1)
            begin
                r.immediate = {8'h00, instr_bytes[p]};
                // one-byte immediate of a word group op widens by sign
                if (c == ibd_pkg::CLS_ALU_IMM_RM && r.sign_extend && r.wide
                    && instr_bytes[p][7])
                begin
                    r.immediate[15:8] = 8'hFF;
                end
            end
            case (c)
                ibd_pkg::CLS_ALU_RM:
                begin
                    r.sub_op      = {1'b0, op[5:3]};
                    r.to_register = op[1];
                end
                ibd_pkg::CLS_ALU_IMM_RM:
                begin
                    r.sub_op = {1'b0, r.reg_field};
                end
                ibd_pkg::CLS_ALU_IMM_ACC:
                begin
                    r.sub_op      = {1'b0, op[5:3]};
                    r.to_register = 1'b1;
                end
                ibd_pkg::CLS_MOV_RM_REG:
                begin
                    r.to_register = op[1];
                end
                ibd_pkg::CLS_MOV_MEM_ACC:
                begin
                    r.to_register = ~op[1];
                end
                ibd_pkg::CLS_MOV_IMM_REG:
                begin
                    r.reg_field   = op[2:0];
                    r.to_register = 1'b1;
                end
                ibd_pkg::CLS_JCC:
                begin
                    r.sub_op      = op[3:0];
                    r.jump_offset = instr_bytes[1];
                end
                ibd_pkg::CLS_LOOP:
                begin
                    r.sub_op      = {2'b00, op[1:0]};
                    r.jump_offset = instr_bytes[1];
                end
                default:
                begin
                end
            endcase
            decodes_due.push_back(r);
            instr_count = 0;
        end
    endtask

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("mismatch %s: expected %h got %h", field, want, got);
        end
    endtask

    task automatic check_decode(input ibd_pkg::result_t g);
        ibd_pkg::result_t e;
        if (decodes_due.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("unexpected word %h", g);
            end
        end
        else
        begin
            e = decodes_due.pop_front();
            if (g.op_class !== e.op_class)
                report_field("op_class", e.op_class, g.op_class);
            if (g.sub_op !== e.sub_op)
                report_field("sub_op", e.sub_op, g.sub_op);
            if (g.mode_field !== e.mode_field)
                report_field("mode_field", e.mode_field, g.mode_field);
            if (g.reg_field !== e.reg_field)
                report_field("reg_field", e.reg_field, g.reg_field);
            if (g.rm_field !== e.rm_field)
                report_field("rm_field", e.rm_field, g.rm_field);
            if (g.wide !== e.wide)
                report_field("wide", e.wide, g.wide);
            if (g.to_register !== e.to_register)
                report_field("to_register", e.to_register, g.to_register);
            if (g.sign_extend !== e.sign_extend)
                report_field("sign_extend", e.sign_extend, g.sign_extend);
            if (g.displacement !== e.displacement)
                report_field("displacement", e.displacement, g.displacement);
            if (g.immediate !== e.immediate)
                report_field("immediate", e.immediate, g.immediate);
            if (g.jump_offset !== e.jump_offset)
                report_field("jump_offset", e.jump_offset, g.jump_offset);
            if (g.length !== e.length)
                report_field("length", e.length, g.length);
            if (g.pad !== e.pad)
                report_field("pad", e.pad, g.pad);
        end
    endtask

    // Output side: random backpressure, result checks, stall counter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= idle_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (m_tvalid && m_tready)
            begin
                check_decode(ibd_pkg::result_t'(m_tdata));
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("TB_ERROR");
        $finish;
    end

    // Called at a rising edge; returns at the edge that takes the word.
    // Valid stays high on return so back-to-back words need no toggle.
    task automatic send_byte(input logic [7:0] b);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_byte(b);
    endtask

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] make_opcode(input ibd_pkg::op_class_t k);
        logic [7:0] cand;
        do
        begin
            cand = 8'($urandom);
            if (k != ibd_pkg::CLS_UNKNOWN)
            begin
                cand = (cand & ~OPC_MASK[int'(k)]) | OPC_CODE[int'(k)];
            end
        end
        while (find_class(cand) != k);
        return cand;
    endfunction

    // One well-formed instruction of a random class with random content
    task automatic send_instr();
        ibd_pkg::op_class_t k;
        logic [7:0]         modrm;
        k = ibd_pkg::op_class_t'(4'($urandom_range(0, 9)));
        send_byte(make_opcode(k));
        if (instr_count != 0 && takes_modrm(k))
        begin
            modrm = {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                     (($urandom_range(0, 3) == 0) ? 3'd6 : 3'($urandom_range(0, 7)))};
            send_byte(modrm);
        end
        while (instr_count != 0)
        begin
            send_byte(pick_data_byte());
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (decodes_due.size() != 0);
    endtask

    task automatic test_directed();
        logic [7:0] seq [$];
        seq = '{
            8'hFF,                                  // unknown opcode
            8'h03, 8'h45, 8'h80,                    // negative 8-bit displacement
            8'h83, 8'h06, 8'h34, 8'h12, 8'h80,      // direct address, widened imm
            8'h81, 8'h86, 8'h00, 8'h80, 8'hFF, 8'hFF, // six-byte form
            8'h3D, 8'hFF, 8'hFF,                    // accumulator immediate, word
            8'h8A, 8'hF9,                           // mov reg, register direct
            8'hA2, 8'h00, 8'h80,                    // store to address, byte
            8'hA1, 8'hFF, 8'h7F,                    // load from address, word
            8'hBF, 8'h01, 8'h80,                    // mov imm to reg, word
            8'hC6, 8'hF8, 8'h5A,                    // mov imm to r/m, reg bits set
            8'h70, 8'h80,                           // jcc, most negative offset
            8'hE3, 8'h7F                            // jcxz, most positive offset
        };
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    task automatic test_random_stream(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_byte(8'($urandom));
                sent++;
            end
            else
            begin
                sent -= instr_count;
                send_instr();
                sent += 1 + 5 * 0;
                sent += decodes_due.size() > 0 ? decodes_due[$].length - 1 : 0;
            end
        end
    endtask

    task automatic test_drain_pause();
        for (int round = 0; round < 4; round++)
        begin
            for (int i = 0; i < 10; i++)
            begin
                send_instr();
            end
            hold_until_drained();
        end
    endtask

    task automatic test_full_rate(input int n_instr);
        idle_en <= 1'b0;
        for (int i = 0; i < n_instr; i++)
        begin
            send_instr();
        end
        idle_en <= 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream(1200);
        test_drain_pause();
        test_full_rate(100);
        test_random_stream(200);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && decodes_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
